// ===== sv/ehash_pkg.sv =====
// ----------------------------------------------------------------------------
// ehash_pkg
// Shared codes, widths and the control state type of the extendible hash table.
// ----------------------------------------------------------------------------
package ehash_pkg;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int ENTRY_W  = 11;
	localparam int CAP_W    = 3;

	// request codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

	localparam logic [CAP_W-1:0] CAP_RESET = 3'd4;

	// control sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_DIR,
		ST_RD_BKT,
		ST_EXEC,
		ST_DOUBLE,
		ST_ALLOC,
		ST_WR_NB,
		ST_REPOINT,
		ST_RESP
	} ehash_state_t;

endpackage

// ===== sv/ehash_ifs.sv =====
// ----------------------------------------------------------------------------
// ehash channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ehash_req_if #(
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
);
	logic                                valid;
	logic                                ready;
	logic [ehash_pkg::OP_W-1:0]          op;
	logic signed [KEY_WIDTH-1:0]         key;
	logic [VALUE_WIDTH-1:0]              value;

	modport source (output valid, op, key, value, input ready);
	modport sink   (input valid, op, key, value, output ready);
endinterface

interface ehash_rsp_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                                valid;
	logic                                ready;
	logic [ehash_pkg::STATUS_W-1:0]      status;
	logic [VALUE_WIDTH-1:0]              found_value;
	logic [ehash_pkg::ENTRY_W-1:0]       entry_total;

	modport source (output valid, status, found_value, entry_total, input ready);
	modport sink   (input valid, status, found_value, entry_total, output ready);
endinterface

// ===== sv/ehash_ram.sv =====
// ----------------------------------------------------------------------------
// ehash_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ehash_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/extendible_hash_table.sv =====
// ----------------------------------------------------------------------------
// extendible_hash_table
// Extendible hash table on integer keys: insert/update, search, remove.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  req       in   op, key, value
//  rsp       out  status, found_value, entry_total
//  cfg       in   cfg_we / cfg_data: bucket capacity
//
// Without a split the result beat follows the request beat through the
// directory read, bucket row read, read-modify-write step and result load;
// the next request is taken once the sequencer is back in its idle state.
// Each split adds a repoint sweep over the directory, two row writes and a
// lookup again; a directory doubling adds a copy sweep over the old directory.
// After reset a clearing pass over all 2^MAX_GLOBAL_DEPTH rows (256 by default)
// initializes both memories; no request is taken until it ends.
// A stalled response holds the sequencer in its result step; one more request
// may be taken while a result waits.
module extendible_hash_table #(
	parameter int MAX_GLOBAL_DEPTH = 8,
	parameter int BUCKET_SLOTS     = 4,
	parameter int KEY_WIDTH        = 32,
	parameter int VALUE_WIDTH      = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ehash_pkg::CAP_W-1:0] cfg_data,
	ehash_req_if.sink                  req,
	ehash_rsp_if.source                rsp
);
	import ehash_pkg::*;

	localparam int MGD  = MAX_GLOBAL_DEPTH;
	localparam int BS   = BUCKET_SLOTS;
	localparam int KW   = KEY_WIDTH;
	localparam int VW   = VALUE_WIDTH;
	localparam int NB   = 1 << MGD;
	localparam int GW   = $clog2(MGD + 1);
	localparam int FW   = $clog2(BS + 1);
	localparam int IW   = (BS > 1) ? $clog2(BS) : 1;
	localparam int XW   = KW + MGD;

	typedef struct packed {
		logic [GW-1:0]          depth;
		logic [FW-1:0]          fill;
		logic [BS-1:0][KW-1:0]  keys;
		logic [BS-1:0][VW-1:0]  vals;
	} row_t;

	localparam int RW = $bits(row_t);

	// bit of the sign-extended key at position idx
	function automatic logic key_bit(input logic [KW-1:0] k, input logic [GW-1:0] idx);
		logic [XW-1:0] ext;
		logic [XW-1:0] sel;
		ext = {{MGD{k[KW-1]}}, k};
		sel = XW'(1) << idx;
		return |(ext & sel);
	endfunction

	ehash_state_t state_q, state_nx;

	logic [CAP_W-1:0]  cap_q;
	logic [OP_W-1:0]   op_q;
	logic [KW-1:0]     key_q;
	logic [VW-1:0]     val_q;
	logic [GW-1:0]     gd_q;
	logic [MGD:0]      used_q;
	logic [ENTRY_W-1:0] total_q;
	logic [MGD-1:0]    b_q;
	logic [MGD-1:0]    nb_q;
	row_t              row_q;
	logic [STATUS_W-1:0] st_q;
	logic [VW-1:0]     fv_q;
	logic [MGD:0]      cnt_q;
	logic              p_s1;
	logic [MGD-1:0]    addr_s1;

	logic              out_v_q;
	logic [STATUS_W-1:0] out_st_q;
	logic [VW-1:0]     out_fv_q;
	logic [ENTRY_W-1:0] out_tot_q;

	// memory ports
	logic              dir_we, dir_re;
	logic [MGD-1:0]    dir_waddr, dir_raddr, dir_wdata, dir_rdata;
	logic              bkt_we, bkt_re;
	logic [MGD-1:0]    bkt_waddr, bkt_raddr;
	row_t              bkt_wdata, bkt_rdata;

	ehash_ram #(.WIDTH(MGD), .DEPTH(NB)) u_dir (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (dir_re),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	ehash_ram #(.WIDTH(RW), .DEPTH(NB)) u_bkt (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_waddr),
		.wdata (bkt_wdata),
		.re    (bkt_re),
		.raddr (bkt_raddr),
		.rdata (bkt_rdata)
	);

	// directory slot of the current key
	logic [MGD:0]   gmask;
	logic [XW-1:0]  key_ext;
	logic [MGD-1:0] slot;
	assign gmask   = ((MGD+1)'(1) << gd_q) - (MGD+1)'(1);
	assign key_ext = {{MGD{key_q[KW-1]}}, key_q};
	assign slot    = key_ext[MGD-1:0] & gmask[MGD-1:0];

	// sweep length and progress
	logic [MGD:0] sz;
	logic         sw_re, sw_done;
	assign sz      = (MGD+1)'(1) << gd_q;
	assign sw_re   = (cnt_q < sz);
	assign sw_done = !sw_re && !p_s1;

	logic clr_last;
	assign clr_last = (cnt_q == (MGD+1)'(NB - 1));

	// effective capacity
	logic [FW-1:0] eff_cap;
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = FW'(1);
		end else if (int'(cap_q) > BS) begin
			eff_cap = FW'(BS);
		end else begin
			eff_cap = FW'(cap_q);
		end
	end

	// key match over the bucket row
	logic          hit;
	logic [IW-1:0] pos;
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = BS - 1; i >= 0; i--) begin
			if ((i < int'(bkt_rdata.fill)) && (bkt_rdata.keys[i] == key_q)) begin
				hit = 1'b1;
				pos = IW'(i);
			end
		end
	end

	// modified rows for update, append and remove
	row_t upd_row, app_row, rem_row;
	always_comb begin
		upd_row = bkt_rdata;
		upd_row.vals[pos] = val_q;
		app_row = bkt_rdata;
		app_row.keys[bkt_rdata.fill[IW-1:0]] = key_q;
		app_row.vals[bkt_rdata.fill[IW-1:0]] = val_q;
		app_row.fill = bkt_rdata.fill + FW'(1);
		rem_row = bkt_rdata;
		for (int i = 0; i < BS - 1; i++) begin
			if ((i >= int'(pos)) && (i + 1 < int'(bkt_rdata.fill))) begin
				rem_row.keys[i] = bkt_rdata.keys[i+1];
				rem_row.vals[i] = bkt_rdata.vals[i+1];
			end
		end
		rem_row.fill = bkt_rdata.fill - FW'(1);
	end

	// split partition of the held row on key bit at the old depth
	row_t          keep_row, move_row;
	logic [FW-1:0] kc, mc;
	logic [GW-1:0] od;
	assign od = row_q.depth;
	always_comb begin
		keep_row = row_q;
		move_row = row_q;
		kc = '0;
		mc = '0;
		for (int i = 0; i < BS; i++) begin
			if (i < int'(row_q.fill)) begin
				if (key_bit(row_q.keys[i], od)) begin
					move_row.keys[mc[IW-1:0]] = row_q.keys[i];
					move_row.vals[mc[IW-1:0]] = row_q.vals[i];
					mc = mc + FW'(1);
				end else begin
					keep_row.keys[kc[IW-1:0]] = row_q.keys[i];
					keep_row.vals[kc[IW-1:0]] = row_q.vals[i];
					kc = kc + FW'(1);
				end
			end
		end
		keep_row.fill  = kc;
		move_row.fill  = mc;
		keep_row.depth = od + GW'(1);
		move_row.depth = od + GW'(1);
	end

	// directory bit test for repointing
	logic [MGD-1:0] dbit;
	assign dbit = MGD'(1) << od;

	logic full_split;
	assign full_split = (bkt_rdata.depth >= gd_q) && (int'(gd_q) >= MGD);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_last) state_nx = ST_IDLE;
			ST_IDLE:    if (req.valid) state_nx = ST_RD_DIR;
			ST_RD_DIR:  state_nx = ST_RD_BKT;
			ST_RD_BKT:  state_nx = ST_EXEC;
			ST_EXEC: begin
				state_nx = ST_RESP;
				if (op_q == OP_INSERT && !hit && !(bkt_rdata.fill < eff_cap)) begin
					if (full_split) begin
						state_nx = ST_RESP;
					end else if (bkt_rdata.depth >= gd_q) begin
						state_nx = ST_DOUBLE;
					end else begin
						state_nx = ST_ALLOC;
					end
				end
			end
			ST_DOUBLE:  if (sw_done) state_nx = ST_ALLOC;
			ST_ALLOC:   state_nx = (used_q >= (MGD+1)'(NB)) ? ST_RESP : ST_WR_NB;
			ST_WR_NB:   state_nx = ST_REPOINT;
			ST_REPOINT: if (sw_done) state_nx = ST_RD_DIR;
			ST_RESP:    if (!out_v_q) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		dir_we    = 1'b0;
		dir_waddr = addr_s1;
		dir_wdata = dir_rdata;
		dir_re    = 1'b0;
		dir_raddr = cnt_q[MGD-1:0];
		bkt_we    = 1'b0;
		bkt_waddr = b_q;
		bkt_wdata = bkt_rdata;
		bkt_re    = 1'b0;
		bkt_raddr = dir_rdata;
		case (state_q)
			ST_CLEAR: begin
				dir_we    = 1'b1;
				dir_waddr = cnt_q[MGD-1:0];
				dir_wdata = (cnt_q[MGD-1:0] == MGD'(1)) ? MGD'(1) : '0;
				bkt_we    = 1'b1;
				bkt_waddr = cnt_q[MGD-1:0];
				bkt_wdata = '0;
				bkt_wdata.depth = (cnt_q < (MGD+1)'(2)) ? GW'(1) : '0;
			end
			ST_RD_DIR: begin
				dir_re    = 1'b1;
				dir_raddr = slot;
			end
			ST_RD_BKT: begin
				bkt_re = 1'b1;
			end
			ST_EXEC: begin
				if (op_q == OP_INSERT) begin
					if (hit) begin
						bkt_we    = 1'b1;
						bkt_wdata = upd_row;
					end else if (bkt_rdata.fill < eff_cap) begin
						bkt_we    = 1'b1;
						bkt_wdata = app_row;
					end
				end else if (op_q == OP_REMOVE && hit) begin
					bkt_we    = 1'b1;
					bkt_wdata = rem_row;
				end
			end
			ST_DOUBLE: begin
				dir_re    = sw_re;
				dir_we    = p_s1;
				dir_waddr = addr_s1 + sz[MGD-1:0];
			end
			ST_ALLOC: begin
				bkt_we    = (used_q < (MGD+1)'(NB));
				bkt_wdata = keep_row;
			end
			ST_WR_NB: begin
				bkt_we    = 1'b1;
				bkt_waddr = nb_q;
				bkt_wdata = move_row;
			end
			ST_REPOINT: begin
				dir_re    = sw_re;
				dir_we    = p_s1 && (dir_rdata == b_q) && (|(addr_s1 & dbit));
				dir_wdata = nb_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cap_q   <= CAP_RESET;
			gd_q    <= GW'(1);
			used_q  <= (MGD+1)'(2);
			total_q <= '0;
			cnt_q   <= '0;
			p_s1    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			p_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: cnt_q <= cnt_q + (MGD+1)'(1);
				ST_EXEC: begin
					cnt_q <= '0;
					if (op_q == OP_INSERT && hit) begin
						total_q <= total_q;
					end else if (op_q == OP_INSERT && bkt_rdata.fill < eff_cap) begin
						total_q <= total_q + ENTRY_W'(1);
					end else if (op_q == OP_REMOVE && hit) begin
						total_q <= total_q - ENTRY_W'(1);
					end
				end
				ST_DOUBLE: begin
					if (sw_re) begin
						cnt_q <= cnt_q + (MGD+1)'(1);
						p_s1  <= 1'b1;
					end
					if (sw_done) begin
						gd_q <= gd_q + GW'(1);
					end
				end
				ST_ALLOC: begin
					if (used_q < (MGD+1)'(NB)) begin
						used_q <= used_q + (MGD+1)'(1);
					end
				end
				ST_WR_NB: cnt_q <= '0;
				ST_REPOINT: begin
					if (sw_re) begin
						cnt_q <= cnt_q + (MGD+1)'(1);
						p_s1  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.op;
			key_q <= req.key;
			val_q <= req.value;
		end
		addr_s1 <= cnt_q[MGD-1:0];
		if (state_q == ST_RD_BKT) begin
			b_q <= dir_rdata;
		end
		if (state_q == ST_ALLOC) begin
			nb_q <= used_q[MGD-1:0];
			st_q <= STAT_FULL;
			fv_q <= '0;
		end
		if (state_q == ST_EXEC) begin
			row_q <= bkt_rdata;
			fv_q  <= '0;
			st_q  <= STAT_NOT_FOUND;
			case (op_q)
				OP_INSERT: begin
					if (hit) begin
						st_q <= STAT_UPDATED;
					end else if (bkt_rdata.fill < eff_cap) begin
						st_q <= STAT_INSERTED;
					end else begin
						st_q <= STAT_FULL;
					end
				end
				OP_SEARCH: begin
					if (hit) begin
						st_q <= STAT_FOUND;
						fv_q <= bkt_rdata.vals[pos];
					end
				end
				OP_REMOVE: begin
					if (hit) begin
						st_q <= STAT_REMOVED;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_RESP && !out_v_q) begin
			out_st_q  <= st_q;
			out_fv_q  <= fv_q;
			out_tot_q <= total_q;
		end
	end

	// response beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_RESP && !out_v_q) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_st_q;
	assign rsp.found_value = out_fv_q;
	assign rsp.entry_total = out_tot_q;

`ifndef SYNTHESIS
	// no request taken during the clearing pass
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request accepted during clearing pass");

	// idle never touches the memories
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!bkt_we && !dir_we))
		else $error("memory write while idle");

	// bucket count never exceeds directory size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= sz)
		else $error("more buckets than directory slots");

	// full status only at the depth limit
	a_full_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STAT_FULL) |-> (int'(gd_q) == MGD))
		else $error("full status below maximum depth");
`endif

endmodule
